// ----- hw/rtl/vpsc_pkg.sv -----
// Shared types and character codes for the path safety checker.
`default_nettype none
package vpsc_pkg;

   // Character codes the rules look for
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LSQ   = 8'h5B;
   localparam logic [7:0] CH_RSQ   = 8'h5D;

   localparam int unsigned CH_W    = 8;
   localparam int unsigned TDATA_W = 8;
   localparam logic [1:0] PART_LEN_MAX = 2'd2;

   // Bracketed directory phase, one-hot
   typedef enum logic [3:0] {
      DIR_NONE   = 4'b0001,
      DIR_OPEN   = 4'b0010,
      DIR_PARTS  = 4'b0100,
      DIR_CLOSED = 4'b1000
   } dir_phase_type;

   // One input item held in the input register
   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last;
   } item_type;

   // Per-path scan state
   typedef struct packed {
      logic          at_start;
      logic          ended;
      logic          bad;
      logic          prev_dot;
      logic          saw_square;
      logic          saw_angle;
      dir_phase_type dir_phase;
      logic          dir_angle_kind;
      logic [1:0]    part_len;
      logic          part_dash_first;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      at_start:        1'b1,
      ended:           1'b0,
      bad:             1'b0,
      prev_dot:        1'b0,
      saw_square:      1'b0,
      saw_angle:       1'b0,
      dir_phase:       DIR_NONE,
      dir_angle_kind:  1'b0,
      part_len:        2'd0,
      part_dash_first: 1'b0
   };

   // Verdict handed from the rule core to the result register
   typedef struct packed {
      logic valid;
      logic safe;
   } verdict_type;

endpackage
`default_nettype wire

// ----- hw/rtl/vms_path_safety_checker.sv -----
// Top level of the path safety checker: input register, rule core, result register.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata[7:0] = ch, req_tlast = last
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata[0] = safe, [7:1] = 0
//
// One character item per cycle is accepted while the result side does not stall.
// A held item passes through the rule core into the result register, which shows
// the verdict on rsp_tvalid. A stalled result side holds the verdict and stops the
// input register from advancing, which in turn drops req_tready. Synchronous reset
// returns the scan state to the start of a new path and empties both registers.
`default_nettype none
module vms_path_safety_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] ch
   input  wire logic       req_tlast,   // last
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] safe, [7:1] zero
);

   vpsc_pkg::item_type    item;
   vpsc_pkg::verdict_type verdict;
   logic                  item_valid;
   logic                  load_ok;
   logic                  step;

   // Move the held item through the rules when the result register is free
   assign step = item_valid && load_ok;

   vpsc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (step),
      .item_valid (item_valid),
      .item       (item)
   );

   vpsc_rule_core u_rule_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (item),
      .verdict (verdict)
   );

   vpsc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .verdict    (verdict),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/vpsc_in_reg.sv -----
// Input register: captures one character item and offers it to the rule core.
`default_nettype none
module vpsc_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,
   input  wire logic               req_tlast,
   input  wire logic               advance,
   output logic                    item_valid,
   output vpsc_pkg::item_type      item
);

   logic               valid_ff, valid_in;
   vpsc_pkg::item_type item_ff, item_in;
   logic               take;

   // Accept whenever the held item moves on in this cycle or none is held
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in     = 1'b1;
         item_in.ch   = req_tdata[vpsc_pkg::CH_W-1:0];
         item_in.last = req_tlast;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/vpsc_rule_core.sv -----
// Rule core: per-path scan state and the one-character update of every rule.
`default_nettype none
module vpsc_rule_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire vpsc_pkg::item_type    item,
   output vpsc_pkg::verdict_type      verdict
);

   vpsc_pkg::scan_state_type st_ff, st_in, nx;
   logic [7:0] c;
   logic       first, is_open, is_close, is_own_open;
   logic       ok;

   assign c = item.ch;

   // Apply one character to the scan state
   always_comb begin
      nx          = st_ff;
      first       = st_ff.at_start;
      is_open     = (c == vpsc_pkg::CH_LSQ) || (c == vpsc_pkg::CH_LT);
      is_close    = st_ff.dir_angle_kind ? (c == vpsc_pkg::CH_GT) : (c == vpsc_pkg::CH_RSQ);
      is_own_open = st_ff.dir_angle_kind ? (c == vpsc_pkg::CH_LT) : (c == vpsc_pkg::CH_LSQ);
      if (!st_ff.ended) begin
         if (c == vpsc_pkg::CH_NUL) begin
            nx.ended = 1'b1;
         end else begin
            nx.at_start = 1'b0;
            if (first && c == vpsc_pkg::CH_SLASH) nx.bad = 1'b1;
            if (c == vpsc_pkg::CH_COLON) nx.bad = 1'b1;
            if (c == vpsc_pkg::CH_DOT && st_ff.prev_dot) nx.bad = 1'b1;
            if (c == vpsc_pkg::CH_LSQ) nx.saw_square = 1'b1;
            if (c == vpsc_pkg::CH_LT) nx.saw_angle = 1'b1;
            if (nx.saw_square && nx.saw_angle) nx.bad = 1'b1;

            // Directory tracking
            case (st_ff.dir_phase)
               vpsc_pkg::DIR_NONE: begin
                  if (is_open) begin
                     if (first) begin
                        nx.dir_phase      = vpsc_pkg::DIR_OPEN;
                        nx.dir_angle_kind = (c == vpsc_pkg::CH_LT);
                     end else begin
                        nx.bad = 1'b1;
                     end
                  end
               end
               vpsc_pkg::DIR_OPEN: begin
                  if (is_close) begin
                     nx.dir_phase = vpsc_pkg::DIR_CLOSED;
                  end else if (c == vpsc_pkg::CH_DOT) begin
                     nx.dir_phase       = vpsc_pkg::DIR_PARTS;
                     nx.part_len        = 2'd0;
                     nx.part_dash_first = 1'b0;
                  end else begin
                     nx.bad = 1'b1;
                  end
               end
               vpsc_pkg::DIR_PARTS: begin
                  if (is_close || c == vpsc_pkg::CH_DOT) begin
                     // Close the component; a lone dash is rejected
                     if (st_ff.part_len == 2'd1 && st_ff.part_dash_first) nx.bad = 1'b1;
                     nx.part_len        = 2'd0;
                     nx.part_dash_first = 1'b0;
                     if (is_close) nx.dir_phase = vpsc_pkg::DIR_CLOSED;
                  end else begin
                     if (st_ff.part_len == 2'd0) nx.part_dash_first = (c == vpsc_pkg::CH_DASH);
                     if (st_ff.part_len < vpsc_pkg::PART_LEN_MAX)
                        nx.part_len = st_ff.part_len + 2'd1;
                  end
               end
               default: begin
                  if (is_close || is_own_open) nx.bad = 1'b1;
               end
            endcase

            nx.prev_dot = (c == vpsc_pkg::CH_DOT);
         end
      end
   end

   // Verdict on the last item, then back to the reset state
   assign ok = !nx.bad && !nx.at_start
            && nx.dir_phase != vpsc_pkg::DIR_OPEN && nx.dir_phase != vpsc_pkg::DIR_PARTS;

   always_comb begin
      st_in = st_ff;
      if (step) st_in = item.last ? vpsc_pkg::SCAN_RESET : nx;
   end

   assign verdict.valid = step && item.last;
   assign verdict.safe  = ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= vpsc_pkg::SCAN_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/vpsc_out_reg.sv -----
// Result register: holds one verdict until the result side takes it.
`default_nettype none
module vpsc_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vpsc_pkg::verdict_type verdict,
   output logic                       load_ok,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata
);

   logic valid_ff, valid_in;
   logic safe_ff, safe_in;

   // Free when empty or the held verdict leaves in this cycle
   assign load_ok = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      safe_in  = safe_ff;
      if (load_ok) begin
         valid_in = verdict.valid;
         safe_in  = verdict.safe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      safe_ff <= safe_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(vpsc_pkg::TDATA_W-1){1'b0}}, safe_ff};

endmodule
`default_nettype wire

// ----- hw/rtl/vpsc_checker.sv -----
// Port-level checks for the path safety checker, bound to the top level.
`default_nettype none
module vpsc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // A stalled verdict holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("verdict changed while stalled");

   // Only the verdict bit may be set
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("result padding not zero");

   // Reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // With no verdict waiting, the input side is never stalled
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled without a waiting verdict");

   // With req_tvalid low at both past samples and no verdict shown, an empty pipe produces no verdict in the next cycle
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!rsp_tvalid) && $past(!req_tvalid, 2) && $past(!req_tvalid)
      |=> !rsp_tvalid)
      else $error("verdict without a last item");

endmodule

bind vms_path_safety_checker vpsc_checker u_vpsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
